FILE: rtl/jts_pkg.sv
// Package for the JSON token serializer: operation and token codes, text bytes,
// the job record handed from the token checker to the output sequencer.
// No dependencies.
package jts_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int MAX_BYTES       = 12;
    localparam int MAX_DIGITS      = 10;

    typedef enum logic [2:0] {
        OP_BEGIN_OBJ = 3'd0,
        OP_BEGIN_ARR = 3'd1,
        OP_END_OBJ   = 3'd2,
        OP_END_ARR   = 3'd3,
        OP_STRING    = 3'd4,
        OP_NAME      = 3'd5,
        OP_LITERAL   = 3'd6,
        OP_INTEGER   = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        TK_NONE      = 4'd0,
        TK_BEGIN_OBJ = 4'd1,
        TK_BEGIN_ARR = 4'd2,
        TK_END_OBJ   = 4'd3,
        TK_END_ARR   = 4'd4,
        TK_NAME      = 4'd5,
        TK_STRING    = 4'd6,
        TK_NUMBER    = 4'd7,
        TK_TRUE      = 4'd8,
        TK_FALSE     = 4'd9,
        TK_NULL      = 4'd10
    } token_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD      = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [1:0] LIT_NULL  = 2'd0;
    localparam logic [1:0] LIT_TRUE  = 2'd1;
    localparam logic [1:0] LIT_FALSE = 2'd2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // lowest byte is sent first
    localparam logic [39:0] TXT_NULL  = 40'h00_6C_6C_75_6E;
    localparam logic [39:0] TXT_TRUE  = 40'h00_65_75_72_74;
    localparam logic [39:0] TXT_FALSE = 40'h65_73_6C_61_66;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_CONV,
        EM_SEND
    } em_state_t;

    typedef struct packed {
        logic                        present;
        logic [1:0]                  status;
        logic [3:0]                  len;
        logic [MAX_BYTES-1:0][7:0]   bytes;
        logic                        is_int;
        logic [31:0]                 mag;
    } job_t;

    typedef struct packed {
        logic                         done;
        logic [3:0]                   nd;
        logic [MAX_DIGITS-1:0][3:0]   digits;
    } conv_res_t;

    typedef struct packed {
        logic [47:0] bytes;
        logic [2:0]  n;
    } esc_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + 8'(v)) : (8'h41 + 8'(v) - 8'd10);
    endfunction

    function automatic esc_t escape_byte(input logic [7:0] c);
        esc_t r;
        r.bytes = '0;
        r.n     = 3'd2;
        case (c)
            CH_QUOTE, CH_BSL: r.bytes[15:0] = {c, CH_BSL};
            8'h08:            r.bytes[15:0] = {8'h62, CH_BSL};
            8'h0C:            r.bytes[15:0] = {8'h66, CH_BSL};
            8'h0A:            r.bytes[15:0] = {8'h6E, CH_BSL};
            8'h0D:            r.bytes[15:0] = {8'h72, CH_BSL};
            8'h09:            r.bytes[15:0] = {8'h74, CH_BSL};
            default:
            begin
                if (c < CH_SPACE)
                begin
                    r.bytes = {hex_digit(c[3:0]), hex_digit(c[7:4]), CH_ZERO, CH_ZERO,
                               CH_U, CH_BSL};
                    r.n     = 3'd6;
                end
                else
                begin
                    r.bytes[7:0] = c;
                    r.n          = 3'd1;
                end
            end
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/jts_ctrl.sv
// Token checker: nesting stack, order rules, escaping; builds at most one job per item.
// Depends on jts_pkg.
module jts_ctrl
    import jts_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic [2:0]  operation,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        first_of_string,
    input  logic        last_of_string,
    input  logic [1:0]  lit_sel,
    input  logic [31:0] number_value,
    output logic        item_taken,
    output logic        job_valid,
    output job_t        job,
    input  logic        job_ready
);

    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [STACK_DEPTH-1:0] stack_reg, stack_next;   // bit 0 is the top
    logic [DW-1:0]          depth_reg, depth_next;
    logic                   comma_reg, comma_next;
    token_t                 prev_reg, prev_next;
    logic                   sopen_reg, sopen_next;
    logic                   sname_reg, sname_next;
    logic                   srej_reg, srej_next;

    logic        top_obj, value_ok, name_ok, is_name, err, emits;
    logic [1:0]  err_code;
    logic [95:0] acc;
    logic [3:0]  pos;
    esc_t        esc;
    logic [31:0] neg_num;

    assign top_obj  = (depth_reg != '0) && stack_reg[0];
    assign value_ok = top_obj ? (prev_reg == TK_NAME)
                              : !((depth_reg == '0) && (prev_reg != TK_NONE));
    assign name_ok  = top_obj && (prev_reg != TK_NAME);
    assign is_name  = (operation == OP_NAME);
    assign esc      = escape_byte(data_byte);
    assign neg_num  = 32'd0 - number_value;

    always_comb
    begin
        stack_next = stack_reg;
        depth_next = depth_reg;
        comma_next = comma_reg;
        prev_next  = prev_reg;
        sopen_next = sopen_reg;
        sname_next = sname_reg;
        srej_next  = srej_reg;
        err        = 1'b0;
        err_code   = ST_BAD;
        acc        = '0;
        pos        = 4'd0;
        job        = '0;
        if (operation == OP_STRING || operation == OP_NAME)
        begin
            if (sopen_reg)
            begin
                if (first_of_string || is_name != sname_reg)
                    err = 1'b1;
                else if (srej_reg)
                begin
                    err = 1'b1;
                    if (last_of_string)
                    begin
                        sopen_next = 1'b0;
                        srej_next  = 1'b0;
                    end
                end
            end
            else if (!first_of_string)
                err = 1'b1;
            else if (!(is_name ? name_ok : value_ok))
            begin
                err = 1'b1;
                if (!last_of_string)
                begin
                    sopen_next = 1'b1;
                    sname_next = is_name;
                    srej_next  = 1'b1;
                end
            end
            else
            begin
                if (comma_reg)
                begin
                    acc = 96'(CH_COMMA);
                    pos = 4'd1;
                end
                acc        = acc | (96'(CH_QUOTE) << {pos, 3'b000});
                pos        = pos + 4'd1;
                sopen_next = 1'b1;
                sname_next = is_name;
                srej_next  = 1'b0;
            end
            // body and close for an accepted string item
            if (!err)
            begin
                if (has_byte)
                begin
                    acc = acc | (96'(esc.bytes) << {pos, 3'b000});
                    pos = pos + 4'(esc.n);
                end
                if (last_of_string)
                begin
                    acc = acc | (96'(CH_QUOTE) << {pos, 3'b000});
                    pos = pos + 4'd1;
                    if (sname_next)
                    begin
                        acc        = acc | (96'(CH_COLON) << {pos, 3'b000});
                        pos        = pos + 4'd1;
                        comma_next = 1'b0;
                        prev_next  = TK_NAME;
                    end
                    else
                    begin
                        comma_next = 1'b1;
                        prev_next  = TK_STRING;
                    end
                    sopen_next = 1'b0;
                    srej_next  = 1'b0;
                end
            end
        end
        else if (sopen_reg)
            err = 1'b1;
        else
        begin
            if (comma_reg)
            begin
                acc = 96'(CH_COMMA);
                pos = 4'd1;
            end
            case (operation)
                OP_BEGIN_OBJ, OP_BEGIN_ARR:
                begin
                    if (!value_ok)
                        err = 1'b1;
                    else if (depth_reg >= DW'(STACK_DEPTH))
                    begin
                        err      = 1'b1;
                        err_code = ST_OVERFLOW;
                    end
                    else
                    begin
                        acc = acc | (96'((operation == OP_BEGIN_OBJ) ? CH_LBRC : CH_LBRK)
                                     << {pos, 3'b000});
                        pos = pos + 4'd1;
                        for (int i = 1; i < STACK_DEPTH; i++)
                            stack_next[i] = stack_reg[i-1];
                        stack_next[0] = (operation == OP_BEGIN_OBJ);
                        depth_next    = depth_reg + DW'(1);
                        comma_next    = 1'b0;
                        prev_next     = (operation == OP_BEGIN_OBJ) ? TK_BEGIN_OBJ : TK_BEGIN_ARR;
                    end
                end
                OP_END_OBJ, OP_END_ARR:
                begin
                    if (depth_reg == '0 || prev_reg == TK_NAME ||
                        top_obj != (operation == OP_END_OBJ))
                        err = 1'b1;
                    else
                    begin
                        // no comma before a closing bracket
                        acc = 96'((operation == OP_END_OBJ) ? CH_RBRC : CH_RBRK);
                        pos = 4'd1;
                        for (int i = 0; i < STACK_DEPTH - 1; i++)
                            stack_next[i] = stack_reg[i+1];
                        stack_next[STACK_DEPTH-1] = 1'b0;
                        depth_next = depth_reg - DW'(1);
                        comma_next = 1'b1;
                        prev_next  = (operation == OP_END_OBJ) ? TK_END_OBJ : TK_END_ARR;
                    end
                end
                OP_LITERAL:
                begin
                    if (lit_sel > LIT_FALSE || !value_ok)
                        err = 1'b1;
                    else
                    begin
                        comma_next = 1'b1;
                        case (lit_sel)
                            LIT_NULL:
                            begin
                                acc       = acc | (96'(TXT_NULL) << {pos, 3'b000});
                                pos       = pos + 4'd4;
                                prev_next = TK_NULL;
                            end
                            LIT_TRUE:
                            begin
                                acc       = acc | (96'(TXT_TRUE) << {pos, 3'b000});
                                pos       = pos + 4'd4;
                                prev_next = TK_TRUE;
                            end
                            default:
                            begin
                                acc       = acc | (96'(TXT_FALSE) << {pos, 3'b000});
                                pos       = pos + 4'd5;
                                prev_next = TK_FALSE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    if (!value_ok)
                        err = 1'b1;
                    else
                    begin
                        if (number_value[31])
                        begin
                            acc = acc | (96'(CH_MINUS) << {pos, 3'b000});
                            pos = pos + 4'd1;
                        end
                        job.is_int = 1'b1;
                        job.mag    = number_value[31] ? neg_num : number_value;
                        comma_next = 1'b1;
                        prev_next  = TK_NUMBER;
                    end
                end
            endcase
        end
        if (err)
        begin
            stack_next = stack_reg;
            depth_next = depth_reg;
            comma_next = comma_reg;
            prev_next  = prev_reg;
            if (!(operation == OP_STRING || operation == OP_NAME))
            begin
                sopen_next = sopen_reg;
                sname_next = sname_reg;
                srej_next  = srej_reg;
            end
            job        = '0;
            job.status = err_code;
            job.len    = 4'd1;
        end
        else
        begin
            job.present = 1'b1;
            job.status  = ST_OK;
            job.len     = pos;
            job.bytes   = acc;
        end
    end

    // a middle item with no byte yields nothing
    assign emits      = err || (pos != 4'd0) || job.is_int;
    assign job_valid  = item_valid && emits;
    assign item_taken = item_valid && (job_ready || !emits);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_reg <= '0;
            depth_reg <= '0;
            comma_reg <= 1'b0;
            prev_reg  <= TK_NONE;
            sopen_reg <= 1'b0;
            sname_reg <= 1'b0;
            srej_reg  <= 1'b0;
        end
        else if (item_taken)
        begin
            stack_reg <= stack_next;
            depth_reg <= depth_next;
            comma_reg <= comma_next;
            prev_reg  <= prev_next;
            sopen_reg <= sopen_next;
            sname_reg <= sname_next;
            srej_reg  <= srej_next;
        end
    end

endmodule

FILE: rtl/jts_conv.sv
// Binary to decimal converter, one digit per cycle, least significant first.
// Depends on jts_pkg.
module jts_conv
    import jts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] mag,
    output conv_res_t   res
);

    logic [31:0]                 x_reg;
    logic                        run_reg;
    logic                        done_reg;
    logic [3:0]                  nd_reg;
    logic [MAX_DIGITS-1:0][3:0]  dig_reg;
    logic [63:0]                 prod;
    logic [31:0]                 q;
    logic [31:0]                 r;

    // x / 10 by reciprocal, exact for all 32-bit x
    assign prod = 64'(x_reg) * 64'h0000_0000_CCCC_CCCD;
    assign q    = 32'(prod[63:35]);
    assign r    = x_reg - ((q << 3) + (q << 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (q == 32'd0);
            if (start)
                run_reg <= 1'b1;
            else if (q == 32'd0)
                run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg  <= mag;
            nd_reg <= 4'd0;
        end
        else if (run_reg)
        begin
            x_reg  <= q;
            nd_reg <= nd_reg + 4'd1;
            for (int i = 0; i < MAX_DIGITS; i++)
                if (nd_reg == 4'(i))
                    dig_reg[i] <= r[3:0];
        end
    end

    assign res.done   = done_reg;
    assign res.nd     = nd_reg;
    assign res.digits = dig_reg;

endmodule

FILE: rtl/jts_emit.sv
// Output sequencer: holds one job, sends its bytes one per transfer.
// Depends on jts_pkg and jts_conv results.
module jts_emit
    import jts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_ready,
    output logic        conv_start,
    input  conv_res_t   conv,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte,
    output logic        m_present,
    output logic [1:0]  m_status,
    output logic        m_last
);

    em_state_t                 st_reg, st_next;
    logic [MAX_BYTES-1:0][7:0] buf_reg, buf_next;
    logic [3:0]                len_reg, len_next;
    logic [3:0]                idx_reg, idx_next;
    logic                      pres_reg, pres_next;
    logic [1:0]                stat_reg, stat_next;
    logic                      mv_reg, mv_next;
    logic [7:0]                ob_reg, ob_next;
    logic                      op_reg, op_next;
    logic [1:0]                os_reg, os_next;
    logic                      ol_reg, ol_next;
    logic                      adv, send_last, load;
    logic [3:0]                k, di;

    assign adv       = !mv_reg || m_ready;
    assign send_last = (idx_reg == 4'(len_reg - 4'd1));
    assign job_ready = (st_reg == EM_IDLE) || (st_reg == EM_SEND && adv && send_last);
    assign load      = job_valid && job_ready;
    assign conv_start = load && job.is_int;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            EM_IDLE:
                if (load)
                    st_next = job.is_int ? EM_CONV : EM_SEND;
            EM_CONV:
                if (conv.done)
                    st_next = EM_SEND;
            EM_SEND:
                if (adv && send_last)
                    st_next = load ? (job.is_int ? EM_CONV : EM_SEND) : EM_IDLE;
            default:
                st_next = EM_IDLE;
        endcase
    end

    always_comb
    begin
        buf_next  = buf_reg;
        len_next  = len_reg;
        idx_next  = idx_reg;
        pres_next = pres_reg;
        stat_next = stat_reg;
        mv_next   = mv_reg;
        ob_next   = ob_reg;
        op_next   = op_reg;
        os_next   = os_reg;
        ol_next   = ol_reg;
        k         = 4'd0;
        di        = 4'd0;
        if (st_reg == EM_SEND && adv)
        begin
            mv_next  = 1'b1;
            ob_next  = buf_reg[idx_reg];
            op_next  = pres_reg;
            os_next  = stat_reg;
            ol_next  = send_last;
            idx_next = idx_reg + 4'd1;
        end
        else if (adv)
            mv_next = 1'b0;
        if (st_reg == EM_CONV && conv.done)
        begin
            // digits follow the prefix, most significant first
            for (int i = 0; i < MAX_BYTES; i++)
            begin
                k  = 4'(i) - len_reg;
                di = conv.nd - 4'd1 - k;
                if (4'(i) >= len_reg && k < conv.nd)
                    buf_next[i] = CH_ZERO + 8'(conv.digits[di]);
            end
            len_next = len_reg + conv.nd;
            idx_next = 4'd0;
        end
        if (load)
        begin
            buf_next  = job.bytes;
            len_next  = job.len;
            idx_next  = 4'd0;
            pres_next = job.present;
            stat_next = job.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= EM_IDLE;
            mv_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        pres_reg <= pres_next;
        stat_reg <= stat_next;
        ob_reg   <= ob_next;
        op_reg   <= op_next;
        os_reg   <= os_next;
        ol_reg   <= ol_next;
    end

    assign m_valid   = mv_reg;
    assign m_byte    = ob_reg;
    assign m_present = op_reg;
    assign m_status  = os_reg;
    assign m_last    = ol_reg;

endmodule

FILE: rtl/json_token_serializer.sv
// JSON token serializer: input register, token checker, output sequencer.
// Path: input register, then the sequencer's byte buffer, then the output register;
// an integer first has its decimal digits made by the binary to decimal unit.
// Throughput: one output byte per cycle while m_tready is high and no integer is being
// converted; the next item is taken while the last byte of the current one is sent.
// Reset (rst_n, async low) empties the stack and all token state at once.
module json_token_serializer
    import jts_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // data_byte[7:0], first_of_string[8], lit_sel[10:9],
                                  // number_value[42:11], zero fill
    input  logic [3:0]  s_tuser,  // operation[2:0], has_byte[3]
    input  logic        s_tlast,  // last_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // out_byte[7:0]
    output logic [2:0]  m_tuser,  // byte_present[0], status[2:1]
    output logic        m_tlast   // last_of_run
);

    logic        iv_reg;
    logic [47:0] id_reg;
    logic [3:0]  iu_reg;
    logic        il_reg;
    logic        taken;
    logic        job_valid, job_ready, conv_start;
    job_t        job;
    conv_res_t   conv;
    logic        present;
    logic [1:0]  status;

    assign s_tready = !iv_reg || taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iv_reg <= 1'b0;
        else if (s_tready)
            iv_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            id_reg <= s_tdata;
            iu_reg <= s_tuser;
            il_reg <= s_tlast;
        end
    end

    jts_ctrl #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (iv_reg),
        .operation       (iu_reg[2:0]),
        .data_byte       (id_reg[7:0]),
        .has_byte        (iu_reg[3]),
        .first_of_string (id_reg[8]),
        .last_of_string  (il_reg),
        .lit_sel         (id_reg[10:9]),
        .number_value    (id_reg[42:11]),
        .item_taken      (taken),
        .job_valid       (job_valid),
        .job             (job),
        .job_ready       (job_ready)
    );

    jts_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .mag   (job.mag),
        .res   (conv)
    );

    jts_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job        (job),
        .job_ready  (job_ready),
        .conv_start (conv_start),
        .conv       (conv),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_byte     (m_tdata),
        .m_present  (present),
        .m_status   (status),
        .m_last     (m_tlast)
    );

    assign m_tuser = {status, present};

endmodule

FILE: rtl/jts_checker.sv
// Port-level checks for the JSON token serializer, bound to the top level.
// Depends on json_token_serializer ports only.
module jts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output changed while stalled");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'd0 && m_tuser[2:1] != 2'd0)
        else $error("error transfer is not a lone zero result");

    a_text_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == 2'd0)
        else $error("text byte carries an error status");

endmodule

bind json_token_serializer jts_checker u_jts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
